// ===== rtl/core/lls_pkg.sv =====
package lls_pkg;

    localparam int MAX_LINE      = 1024;
    localparam int MESSAGE_BOUND = 160;

    // position counts up to MAX_LINE, a byte index stays below it
    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int IDX_W = $clog2(MAX_LINE);

    localparam int TAG_CAP_W = 9;
    localparam int MSG_CAP_W = 11;
    localparam int LEVEL_W   = 3;
    localparam int OFF_W     = 10;
    localparam int TAG_LEN_W = 8;
    localparam int MSG_LEN_W = 10;

    localparam logic [TAG_CAP_W-1:0] TAG_CAP_RESET = TAG_CAP_W'(32);
    localparam logic [MSG_CAP_W-1:0] MSG_CAP_RESET = MSG_CAP_W'(161);

    // register index taken from paddr[2]
    localparam logic REG_TAG_CAP = 1'b0;
    localparam logic REG_MSG_CAP = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_UNKNOWN = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_INFO    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_WARN    = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_ERROR   = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_DEBUG   = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_VERBOSE = 3'd5;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_V      = 8'h56;

    typedef enum logic [3:0] {
        PH_START,
        PH_ESC1,
        PH_ESCBODY,
        PH_LEVEL,
        PH_SP1,
        PH_PAREN,
        PH_TS,
        PH_SP2,
        PH_TAG,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // line state after the last byte, handed to the descriptor stage
    typedef struct packed {
        logic               done;
        logic               esc_open;
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   tag_begin;
        logic [IDX_W-1:0]   separator;
        logic [POS_W-1:0]   trimmed_end;
        logic [POS_W-1:0]   escape_end;
        logic               overflow;
    } line_rec_t;

endpackage

// ===== rtl/core/lls_regs.sv =====
module lls_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [lls_pkg::TAG_CAP_W-1:0]  tag_capacity,
    output logic [lls_pkg::MSG_CAP_W-1:0]  message_capacity
);
    import lls_pkg::*;

    logic [TAG_CAP_W-1:0] tag_cap_reg;
    logic [MSG_CAP_W-1:0] msg_cap_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_cap_reg <= TAG_CAP_RESET;
            msg_cap_reg <= MSG_CAP_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_TAG_CAP: tag_cap_reg <= pwdata[TAG_CAP_W-1:0];
                REG_MSG_CAP: msg_cap_reg <= pwdata[MSG_CAP_W-1:0];
                default:     tag_cap_reg <= tag_cap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TAG_CAP: prdata = 32'(tag_cap_reg);
            REG_MSG_CAP: prdata = 32'(msg_cap_reg);
            default:     prdata = '0;
        endcase
    end

    assign tag_capacity     = tag_cap_reg;
    assign message_capacity = msg_cap_reg;

endmodule

// ===== rtl/core/lls_scan.sv =====
module lls_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         line_byte,
    input  logic               line_last,
    input  logic               line_valid,
    output logic               line_ready,
    input  logic               out_free,
    output lls_pkg::line_rec_t rec,
    output logic               rec_load
);
    import lls_pkg::*;

    logic [7:0]         byte_reg;
    logic               last_reg;
    logic               hold_reg;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [POS_W-1:0]   trimmed_end_reg, trimmed_end_next;
    logic [POS_W-1:0]   escape_end_reg, escape_end_next;
    logic [POS_W-1:0]   tag_begin_reg, tag_begin_next;
    logic [IDX_W-1:0]   separator_reg, separator_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               colon_reg, colon_next;
    logic               overflow_reg, overflow_next;

    logic               process;
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   idx_plus;
    logic [LEVEL_W-1:0] byte_level;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [7:0] c);
        logic [LEVEL_W-1:0] lv;
        begin
            case (c)
                CH_I:    lv = LVL_INFO;
                CH_W:    lv = LVL_WARN;
                CH_E:    lv = LVL_ERROR;
                CH_D:    lv = LVL_DEBUG;
                CH_V:    lv = LVL_VERBOSE;
                default: lv = LVL_UNKNOWN;
            endcase
            return lv;
        end
    endfunction

    // a last byte waits here until the result register can take its descriptor
    assign process    = hold_reg && (!last_reg || out_free);
    assign line_ready = !hold_reg || process;
    assign rec_load   = process && last_reg;
    assign byte_level = level_of(byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (line_valid && line_ready)
        begin
            hold_reg <= 1'b1;
        end
        else if (process)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_valid && line_ready)
        begin
            byte_reg <= line_byte;
            last_reg <= line_last;
        end
    end

    // saturating byte index
    always_comb
    begin
        if (position_reg >= POS_W'(MAX_LINE))
        begin
            idx           = IDX_W'(MAX_LINE - 1);
            position_next = position_reg;
            overflow_next = 1'b1;
        end
        else
        begin
            idx           = position_reg[IDX_W-1:0];
            position_next = position_reg + POS_W'(1);
            overflow_next = overflow_reg;
        end
        idx_plus = POS_W'(idx) + POS_W'(1);
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_START:
            begin
                if (byte_reg == CH_ESC)
                    phase_next = PH_ESC1;
                else if (byte_level != LVL_UNKNOWN)
                    phase_next = PH_SP1;
                else
                    phase_next = PH_FAIL;
            end
            PH_ESC1:    phase_next = (byte_reg == CH_LBRACK) ? PH_ESCBODY : PH_FAIL;
            PH_ESCBODY: phase_next = (byte_reg == CH_M) ? PH_LEVEL : PH_ESCBODY;
            PH_LEVEL:   phase_next = (byte_level != LVL_UNKNOWN) ? PH_SP1 : PH_FAIL;
            PH_SP1:     phase_next = (byte_reg == CH_SPACE) ? PH_PAREN : PH_FAIL;
            PH_PAREN:   phase_next = (byte_reg == CH_LPAREN) ? PH_TS : PH_FAIL;
            PH_TS:      phase_next = (byte_reg == CH_RPAREN) ? PH_SP2 : PH_TS;
            PH_SP2:     phase_next = (byte_reg == CH_SPACE) ? PH_TAG : PH_FAIL;
            PH_TAG:
            begin
                if (colon_reg && byte_reg == CH_SPACE)
                    phase_next = PH_DONE;
            end
            default:    phase_next = phase_reg;
        endcase
    end

    always_comb
    begin
        trimmed_end_next = trimmed_end_reg;
        escape_end_next  = escape_end_reg;
        tag_begin_next   = tag_begin_reg;
        separator_next   = separator_reg;
        level_next       = level_reg;
        colon_next       = colon_reg;

        if (byte_reg != CH_CR && byte_reg != CH_LF)
            trimmed_end_next = idx_plus;

        case (phase_reg)
            PH_START,
            PH_LEVEL:
            begin
                if (!(phase_reg == PH_START && byte_reg == CH_ESC) && byte_level != LVL_UNKNOWN)
                    level_next = byte_level;
            end
            PH_ESCBODY:
            begin
                if (byte_reg == CH_M)
                    escape_end_next = idx_plus;
            end
            PH_SP2:
            begin
                if (byte_reg == CH_SPACE)
                begin
                    tag_begin_next = idx_plus;
                    colon_next     = 1'b0;
                end
            end
            PH_TAG:
            begin
                if (!(colon_reg && byte_reg == CH_SPACE))
                begin
                    if (byte_reg == CH_COLON)
                    begin
                        separator_next = idx;
                        colon_next     = 1'b1;
                    end
                    else
                    begin
                        colon_next = 1'b0;
                    end
                end
            end
            default:
            begin
                colon_next = colon_reg;
            end
        endcase
    end

    always_comb
    begin
        rec.done        = (phase_next == PH_DONE);
        rec.esc_open    = (phase_next == PH_ESC1) || (phase_next == PH_ESCBODY);
        rec.level       = level_next;
        rec.tag_begin   = tag_begin_next;
        rec.separator   = separator_next;
        rec.trimmed_end = trimmed_end_next;
        rec.escape_end  = escape_end_next;
        rec.overflow    = overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            position_reg    <= '0;
            trimmed_end_reg <= '0;
            escape_end_reg  <= '0;
            tag_begin_reg   <= '0;
            separator_reg   <= '0;
            level_reg       <= LVL_UNKNOWN;
            colon_reg       <= 1'b0;
            overflow_reg    <= 1'b0;
        end
        else if (process)
        begin
            if (last_reg)
            begin
                phase_reg       <= PH_START;
                position_reg    <= '0;
                trimmed_end_reg <= '0;
                escape_end_reg  <= '0;
                tag_begin_reg   <= '0;
                separator_reg   <= '0;
                level_reg       <= LVL_UNKNOWN;
                colon_reg       <= 1'b0;
                overflow_reg    <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                position_reg    <= position_next;
                trimmed_end_reg <= trimmed_end_next;
                escape_end_reg  <= escape_end_next;
                tag_begin_reg   <= tag_begin_next;
                separator_reg   <= separator_next;
                level_reg       <= level_next;
                colon_reg       <= colon_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |=> (position_reg == '0) && (phase_reg == PH_START) && !overflow_reg)
        else $error("line state not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        colon_reg |-> (phase_reg == PH_TAG) || (phase_reg == PH_DONE))
        else $error("colon flag set outside tag scan");

endmodule

// ===== rtl/core/lls_desc.sv =====
module lls_desc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lls_pkg::line_rec_t             rec,
    input  logic                           rec_load,
    input  logic [lls_pkg::TAG_CAP_W-1:0]  tag_capacity,
    input  logic [lls_pkg::MSG_CAP_W-1:0]  message_capacity,
    output logic                           out_free,
    output logic                           desc_valid,
    input  logic                           desc_ready,
    output logic [lls_pkg::LEVEL_W-1:0]    level_code,
    output logic                           parsed_ok,
    output logic [lls_pkg::OFF_W-1:0]      tag_offset,
    output logic [lls_pkg::TAG_LEN_W-1:0]  tag_length,
    output logic [lls_pkg::OFF_W-1:0]      message_offset,
    output logic [lls_pkg::MSG_LEN_W-1:0]  message_length,
    output logic                           line_too_long
);
    import lls_pkg::*;

    localparam int CW = (POS_W > MSG_CAP_W) ? POS_W : MSG_CAP_W;

    logic                 valid_reg;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic                 ok_reg, ok_next;
    logic [OFF_W-1:0]     toff_reg, toff_next;
    logic [TAG_LEN_W-1:0] tlen_reg, tlen_next;
    logic [OFF_W-1:0]     moff_reg, moff_next;
    logic [MSG_LEN_W-1:0] mlen_reg, mlen_next;
    logic                 long_reg;

    logic [POS_W-1:0]     mstart;
    logic [POS_W-1:0]     msg_begin;
    logic [POS_W-1:0]     tag_span;
    logic [POS_W-1:0]     msg_span;
    logic [CW-1:0]        tag_clip;
    logic [CW-1:0]        msg_clip;

    function automatic logic [POS_W-1:0] sub_floor(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        begin
            return (a > b) ? a - b : '0;
        end
    endfunction

    function automatic logic [CW-1:0] clip_cap(input logic [CW-1:0] n,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] lim;
        begin
            lim = cap - CW'(1);
            if (cap == '0)
                return '0;
            return (n < lim) ? n : lim;
        end
    endfunction

    function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W-1:0] v);
        begin
            return (v > POS_W'(MAX_LINE - 1)) ? OFF_W'(MAX_LINE - 1) : OFF_W'(v);
        end
    endfunction

    assign out_free = !valid_reg || desc_ready;

    always_comb
    begin
        mstart    = POS_W'(rec.separator) + POS_W'(2);
        msg_begin = rec.done ? mstart : (rec.esc_open ? '0 : rec.escape_end);
        tag_span  = sub_floor(POS_W'(rec.separator), rec.tag_begin);
        msg_span  = sub_floor(rec.trimmed_end, msg_begin);

        // on success the message is bounded before the capacity clip
        if (rec.done && msg_span > POS_W'(MESSAGE_BOUND))
            msg_span = POS_W'(MESSAGE_BOUND);

        tag_clip = clip_cap(CW'(tag_span), CW'(tag_capacity));
        msg_clip = clip_cap(CW'(msg_span), CW'(message_capacity));

        level_next = rec.done ? rec.level : LVL_UNKNOWN;
        ok_next    = rec.done;
        toff_next  = rec.done ? sat_off(rec.tag_begin) : '0;
        tlen_next  = '0;
        if (rec.done)
            tlen_next = (tag_clip > CW'({TAG_LEN_W{1'b1}})) ? '1 : TAG_LEN_W'(tag_clip);
        moff_next  = sat_off(msg_begin);
        mlen_next  = (msg_clip > CW'({MSG_LEN_W{1'b1}})) ? '1 : MSG_LEN_W'(msg_clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rec_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (desc_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_load)
        begin
            level_reg <= level_next;
            ok_reg    <= ok_next;
            toff_reg  <= toff_next;
            tlen_reg  <= tlen_next;
            moff_reg  <= moff_next;
            mlen_reg  <= mlen_next;
            long_reg  <= rec.overflow;
        end
    end

    assign desc_valid     = valid_reg;
    assign level_code     = level_reg;
    assign parsed_ok      = ok_reg;
    assign tag_offset     = toff_reg;
    assign tag_length     = tlen_reg;
    assign message_offset = moff_reg;
    assign message_length = mlen_reg;
    assign line_too_long  = long_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |-> out_free)
        else $error("descriptor loaded over a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> parsed_ok || (tag_length == '0))
        else $error("fallback result with nonempty tag");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && parsed_ok |-> message_length <= MSG_LEN_W'(MESSAGE_BOUND))
        else $error("parsed message exceeds bound");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> parsed_ok == (level_code != LVL_UNKNOWN))
        else $error("level code disagrees with parse flag");

endmodule

// ===== rtl/core/log_line_field_splitter_top.sv =====
// throughput: one byte per cycle, descriptors included, as long as results are taken
// the byte is registered at the input, the line state and descriptor logic sit behind it
// and a result register holds the descriptor until it is taken
// reset: rst_n clears the line state and valid flags, capacities return to 32 and 161
module log_line_field_splitter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic [7:0]                     line_byte,
    input  logic                           line_last,
    input  logic                           line_valid,
    output logic                           line_ready,
    output logic [lls_pkg::LEVEL_W-1:0]    level_code,
    output logic                           parsed_ok,
    output logic [lls_pkg::OFF_W-1:0]      tag_offset,
    output logic [lls_pkg::TAG_LEN_W-1:0]  tag_length,
    output logic [lls_pkg::OFF_W-1:0]      message_offset,
    output logic [lls_pkg::MSG_LEN_W-1:0]  message_length,
    output logic                           line_too_long,
    output logic                           desc_valid,
    input  logic                           desc_ready
);
    import lls_pkg::*;

    logic [TAG_CAP_W-1:0] tag_capacity;
    logic [MSG_CAP_W-1:0] message_capacity;
    line_rec_t            rec;
    logic                 rec_load;
    logic                 out_free;

    lls_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .tag_capacity     (tag_capacity),
        .message_capacity (message_capacity)
    );

    lls_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_byte  (line_byte),
        .line_last  (line_last),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .out_free   (out_free),
        .rec        (rec),
        .rec_load   (rec_load)
    );

    lls_desc u_desc (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec              (rec),
        .rec_load         (rec_load),
        .tag_capacity     (tag_capacity),
        .message_capacity (message_capacity),
        .out_free         (out_free),
        .desc_valid       (desc_valid),
        .desc_ready       (desc_ready),
        .level_code       (level_code),
        .parsed_ok        (parsed_ok),
        .tag_offset       (tag_offset),
        .tag_length       (tag_length),
        .message_offset   (message_offset),
        .message_length   (message_length),
        .line_too_long    (line_too_long)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lls_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 28;
    localparam int DRAIN_PAUSE = 4;

    // line endings appended after the text
    localparam int EOL_NONE = 0;
    localparam int EOL_LF   = 1;
    localparam int EOL_CRLF = 2;
    localparam int EOL_CR   = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } line_byte_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level_code;
        logic                 parsed_ok;
        logic [OFF_W-1:0]     tag_offset;
        logic [TAG_LEN_W-1:0] tag_length;
        logic [OFF_W-1:0]     message_offset;
        logic [MSG_LEN_W-1:0] message_length;
        logic                 line_too_long;
    } descriptor_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic [7:0] line_byte = '0;
    logic line_last = 1'b0;
    logic line_valid = 1'b0;
    logic line_ready;
    logic [LEVEL_W-1:0] level_code;
    logic parsed_ok;
    logic [OFF_W-1:0] tag_offset;
    logic [TAG_LEN_W-1:0] tag_length;
    logic [OFF_W-1:0] message_offset;
    logic [MSG_LEN_W-1:0] message_length;
    logic line_too_long;
    logic desc_valid;
    logic desc_ready = 1'b0;

    line_byte_t  byte_backlog[$];
    descriptor_t due_descs[$];
    int errors = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;

    // capacities as the block should hold them
    int cap_tag = 32;
    int cap_msg = 161;

    // line state of the splitter
    int     ln_pos;
    int     ln_trim_end;
    phase_t ln_phase;
    int     ln_esc_end;
    logic [LEVEL_W-1:0] ln_level;
    int     ln_tag_begin;
    int     ln_sep;
    bit     ln_prev_colon;
    bit     ln_overflow;

    log_line_field_splitter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .line_byte      (line_byte),
        .line_last      (line_last),
        .line_valid     (line_valid),
        .line_ready     (line_ready),
        .level_code     (level_code),
        .parsed_ok      (parsed_ok),
        .tag_offset     (tag_offset),
        .tag_length     (tag_length),
        .message_offset (message_offset),
        .message_length (message_length),
        .line_too_long  (line_too_long),
        .desc_valid     (desc_valid),
        .desc_ready     (desc_ready)
    );

    always #1 clk = ~clk;

    function automatic void clear_line_state();
        ln_pos = 0;
        ln_trim_end = 0;
        ln_phase = PH_START;
        ln_esc_end = 0;
        ln_level = LVL_UNKNOWN;
        ln_tag_begin = 0;
        ln_sep = 0;
        ln_prev_colon = 1'b0;
        ln_overflow = 1'b0;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_for(logic [7:0] c);
        case (c)
            CH_I:    return LVL_INFO;
            CH_W:    return LVL_WARN;
            CH_E:    return LVL_ERROR;
            CH_D:    return LVL_DEBUG;
            CH_V:    return LVL_VERBOSE;
            default: return LVL_UNKNOWN;
        endcase
    endfunction

    function automatic int floor_sub(int a, int b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic int clip_to_cap(int n, int cap);
        if (cap == 0)
        begin
            return 0;
        end
        return (n < cap - 1) ? n : cap - 1;
    endfunction

    // advance the line parse by one byte, queue the descriptor on the last one
    function automatic void advance_line(logic [7:0] c, logic last);
        int idx;
        int mstart;
        int start;
        int toff;
        int tlen;
        int moff;
        int mlen;
        bit take_level;
        logic [LEVEL_W-1:0] lv;
        descriptor_t d;

        take_level = 1'b0;
        if (ln_pos >= MAX_LINE)
        begin
            ln_overflow = 1'b1;
            idx = MAX_LINE - 1;
        end
        else
        begin
            idx = ln_pos;
            ln_pos++;
        end
        if (c != CH_CR && c != CH_LF)
        begin
            ln_trim_end = idx + 1;
        end

        case (ln_phase)
            PH_START:
            begin
                if (c == CH_ESC)
                begin
                    ln_phase = PH_ESC1;
                end
                else
                begin
                    take_level = 1'b1;
                end
            end
            PH_ESC1:    ln_phase = (c == CH_LBRACK) ? PH_ESCBODY : PH_FAIL;
            PH_ESCBODY:
            begin
                if (c == CH_M)
                begin
                    ln_esc_end = idx + 1;
                    ln_phase = PH_LEVEL;
                end
            end
            PH_LEVEL:   take_level = 1'b1;
            PH_SP1:     ln_phase = (c == CH_SPACE) ? PH_PAREN : PH_FAIL;
            PH_PAREN:   ln_phase = (c == CH_LPAREN) ? PH_TS : PH_FAIL;
            PH_TS:
            begin
                if (c == CH_RPAREN)
                begin
                    ln_phase = PH_SP2;
                end
            end
            PH_SP2:
            begin
                if (c == CH_SPACE)
                begin
                    ln_tag_begin = idx + 1;
                    ln_prev_colon = 1'b0;
                    ln_phase = PH_TAG;
                end
                else
                begin
                    ln_phase = PH_FAIL;
                end
            end
            PH_TAG:
            begin
                if (ln_prev_colon && c == CH_SPACE)
                begin
                    ln_phase = PH_DONE;
                end
                else if (c == CH_COLON)
                begin
                    ln_sep = idx;
                    ln_prev_colon = 1'b1;
                end
                else
                begin
                    ln_prev_colon = 1'b0;
                end
            end
            default: ;
        endcase

        if (take_level)
        begin
            lv = level_for(c);
            if (lv != LVL_UNKNOWN)
            begin
                ln_level = lv;
                ln_phase = PH_SP1;
            end
            else
            begin
                ln_phase = PH_FAIL;
            end
        end

        if (!last)
        begin
            return;
        end

        d = '0;
        if (ln_phase == PH_DONE)
        begin
            mstart = ln_sep + 2;
            d.level_code = ln_level;
            d.parsed_ok = 1'b1;
            toff = ln_tag_begin;
            tlen = clip_to_cap(floor_sub(ln_sep, ln_tag_begin), cap_tag);
            moff = mstart;
            mlen = floor_sub(ln_trim_end, mstart);
            mlen = (mlen < MESSAGE_BOUND) ? mlen : MESSAGE_BOUND;
            mlen = clip_to_cap(mlen, cap_msg);
        end
        else
        begin
            // an escape that never closed is not skipped
            start = (ln_phase == PH_ESCBODY || ln_phase == PH_ESC1) ? 0 : ln_esc_end;
            toff = 0;
            tlen = 0;
            moff = start;
            mlen = clip_to_cap(floor_sub(ln_trim_end, start), cap_msg);
        end
        d.tag_offset = OFF_W'((toff < MAX_LINE - 1) ? toff : MAX_LINE - 1);
        d.tag_length = TAG_LEN_W'((tlen < 255) ? tlen : 255);
        d.message_offset = OFF_W'((moff < MAX_LINE - 1) ? moff : MAX_LINE - 1);
        d.message_length = MSG_LEN_W'((mlen < 1023) ? mlen : 1023);
        d.line_too_long = ln_overflow;
        due_descs.push_back(d);
        clear_line_state();
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        line_byte_t nxt;
        if (!rst_n)
        begin
            line_valid <= 1'b0;
        end
        else
        begin
            if (line_valid && line_ready)
            begin
                advance_line(line_byte, line_last);
            end
            if (!line_valid || line_ready)
            begin
                if (byte_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = byte_backlog.pop_front();
                    line_byte <= nxt.data;
                    line_last <= nxt.last;
                    line_valid <= 1'b1;
                end
                else
                begin
                    line_valid <= 1'b0;
                end
            end
        end
    end

    // descriptor monitor
    always @(posedge clk)
    begin
        descriptor_t want;
        if (!rst_n)
        begin
            desc_ready <= 1'b0;
        end
        else
        begin
            if (desc_valid && desc_ready)
            begin
                if (due_descs.size() == 0)
                begin
                    $error("descriptor request with nothing expected");
                    errors++;
                end
                else
                begin
                    want = due_descs.pop_front();
                    check_field("level_code", want.level_code, level_code);
                    check_field("parsed_ok", want.parsed_ok, parsed_ok);
                    check_field("tag_offset", want.tag_offset, tag_offset);
                    check_field("tag_length", want.tag_length, tag_length);
                    check_field("message_offset", want.message_offset, message_offset);
                    check_field("message_length", want.message_length, message_length);
                    check_field("line_too_long", want.line_too_long, line_too_long);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                desc_ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                // long back-pressure so the splitter fills and stalls its input
                hold_taken <= 1'b1;
                stall_left <= HOLD_CYCLES;
                desc_ready <= 1'b0;
            end
            else
            begin
                desc_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (line_valid && line_ready) || (desc_valid && desc_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (byte_backlog.size() != 0 || line_valid || due_descs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic add_text(ref logic [7:0] ln[$], input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            ln.push_back(s[i]);
        end
    endtask

    // random bytes, one value kept out where a field delimiter must not appear
    task automatic add_random(ref logic [7:0] ln[$], input int n, input int avoid);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(255));
            if (int'(b) == avoid)
            begin
                b = b ^ 8'h01;
            end
            ln.push_back(b);
        end
    endtask

    task automatic add_eol(ref logic [7:0] ln[$], input int kind);
        case (kind)
            EOL_LF:   ln.push_back(CH_LF);
            EOL_CRLF:
            begin
                ln.push_back(CH_CR);
                ln.push_back(CH_LF);
            end
            EOL_CR:   ln.push_back(CH_CR);
            default: ;
        endcase
    endtask

    task automatic send_line(input logic [7:0] ln[$]);
        for (int i = 0; i < ln.size(); i++)
        begin
            byte_backlog.push_back('{data: ln[i], last: (i == ln.size() - 1)});
        end
    endtask

    task automatic send_text(input bit esc, input string s, input int eol);
        logic [7:0] ln[$];
        if (esc)
        begin
            ln.push_back(CH_ESC);
        end
        add_text(ln, s);
        add_eol(ln, eol);
        send_line(ln);
    endtask

    task automatic build_good(ref logic [7:0] ln[$], input int msg_n, input int tag_n);
        logic [7:0] lv_chars[5] = '{CH_I, CH_W, CH_E, CH_D, CH_V};
        if ($urandom_range(3) == 0)
        begin
            ln.push_back(CH_ESC);
            ln.push_back(CH_LBRACK);
            add_random(ln, $urandom_range(3), CH_M);
            ln.push_back(CH_M);
        end
        ln.push_back(lv_chars[$urandom_range(4)]);
        add_text(ln, " (");
        add_random(ln, $urandom_range(1, 4), CH_RPAREN);
        add_text(ln, ") ");
        add_random(ln, tag_n, CH_COLON);
        add_text(ln, ": ");
        add_random(ln, msg_n, -1);
        add_eol(ln, $urandom_range(3));
    endtask

    task automatic queue_random_line();
        logic [7:0] ln[$];
        int pick;
        int cut;
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            build_good(ln, $urandom_range(10), $urandom_range(5));
            // damaged lines: one byte overwritten or the tail cut off
            if (pick >= 70)
            begin
                cut = $urandom_range(ln.size() - 1);
                if (pick < 78)
                begin
                    ln[cut] = 8'($urandom_range(255));
                end
                else
                begin
                    while (ln.size() > cut + 1)
                    begin
                        void'(ln.pop_back());
                    end
                end
            end
        end
        else
        begin
            add_random(ln, $urandom_range(1, 12), -1);
        end
        send_line(ln);
    endtask

    task automatic run_phase(input int tag_cap_v, input int msg_cap_v, input int lines);
        wait_idle();
        write_reg({REG_TAG_CAP, 2'b00}, tag_cap_v);
        cap_tag = tag_cap_v;
        write_reg({REG_MSG_CAP, 2'b00}, msg_cap_v);
        cap_msg = msg_cap_v;
        repeat (lines) queue_random_line();
    endtask

    task automatic queue_directed();
        logic [7:0] ln[$];
        send_text(1'b0, "I (100) wifi: connected", EOL_CRLF);
        send_text(1'b0, "W (2) t: m", EOL_NONE);
        send_text(1'b0, "E (33) net: fail", EOL_LF);
        send_text(1'b0, "D (4) x: y", EOL_CR);
        send_text(1'b0, "V (5) v: ", EOL_CRLF);
        send_text(1'b1, "[0;32mI (12) boot: hi", EOL_CRLF);
        // escape never closed, and escape without its bracket
        send_text(1'b1, "[1;31E (7) a: b", EOL_NONE);
        send_text(1'b1, "xI (1) a: b", EOL_NONE);
        send_text(1'b0, "", EOL_CRLF);
        send_text(1'b0, "", EOL_LF);
        send_text(1'b0, "I", EOL_NONE);
        send_text(1'b0, "X (1) a: b", EOL_NONE);
        send_text(1'b0, "I(1) a: b", EOL_NONE);
        send_text(1'b0, "I 1) a: b", EOL_NONE);
        send_text(1'b0, "I (1)a: b", EOL_NONE);
        send_text(1'b0, "W (5) tagonly", EOL_LF);
        send_text(1'b0, "E (9) a:b:c: msg", EOL_NONE);
        send_text(1'b0, "I (1) : msg", EOL_NONE);
        send_text(1'b0, "D (1) t:: x", EOL_NONE);
        send_text(1'b0, "I (1) t:", EOL_NONE);

        add_text(ln, "I (1) z: ");
        ln.push_back(8'h00);
        ln.push_back(8'hFF);
        send_line(ln);
    endtask

    // message past the bound while the message capacity is above it
    task automatic queue_long_message();
        logic [7:0] ln[$];
        add_text(ln, "I (1) log: ");
        add_random(ln, 165, -1);
        send_line(ln);
    endtask

    initial
    begin
        clear_line_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();

        run_phase(0, 0, 3);
        hold_req = 1'b1;
        run_phase(256, 1024, 3);
        queue_long_message();
        wait_idle();
        calm = 1'b1;
        run_phase(1, 1, 5);
        wait_idle();
        calm = 1'b0;
        run_phase(2, 161, 2);
        repeat (2) run_phase($urandom_range(256), $urandom_range(1024), 2);
        run_phase($urandom_range(40), $urandom_range(200), 2);
        wait_idle();

        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lls_pkg.sv
rtl/core/lls_regs.sv
rtl/core/lls_scan.sv
rtl/core/lls_desc.sv
rtl/core/log_line_field_splitter_top.sv
test/tb_top.sv
